/* rtl/mpq_pkg.sv */
// Shared types and codes for the max priority queue.
package mpq_pkg;
    typedef enum logic [1:0] {
        MODE_ENQ  = 2'd0,
        MODE_DEQ  = 2'd1,
        MODE_FIND = 2'd2,
        MODE_SWAP = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SWAP,
        S_SORT,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture input word
        logic exec;   // do enqueue / dequeue / lookup
        logic swap;   // exchange fields in every cell
        logic sort;   // one odd-even transposition pass
        logic emit;   // load output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic sort_done;
    } t_stat;
endpackage

/* rtl/mpq_ctrl.sv */
// Controller state machine for the max priority queue.
module mpq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  mpq_pkg::t_mode i_mode,
    input  logic           i_out_busy,
    input  mpq_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output mpq_pkg::t_cmd  o_cmd
);
    mpq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_mode == mpq_pkg::MODE_SWAP) ? mpq_pkg::S_SWAP
                                                             : mpq_pkg::S_EXEC;
                end
            end
            mpq_pkg::S_EXEC: n_state = mpq_pkg::S_OUT;
            mpq_pkg::S_SWAP: n_state = mpq_pkg::S_SORT;
            mpq_pkg::S_SORT: begin
                if (i_stat.sort_done) begin
                    n_state = mpq_pkg::S_OUT;
                end
            end
            mpq_pkg::S_OUT: begin
                if (!i_out_busy) begin
                    n_state = mpq_pkg::S_IDLE;
                end
            end
            default: n_state = mpq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            mpq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            mpq_pkg::S_EXEC: o_cmd.exec = 1'b1;
            mpq_pkg::S_SWAP: o_cmd.swap = 1'b1;
            mpq_pkg::S_SORT: o_cmd.sort = 1'b1;
            mpq_pkg::S_OUT:  o_cmd.emit = !i_out_busy;
            default: ;
        endcase
    end
endmodule

/* rtl/mpq_datapath.sv */
// Sorted cell chain with output register for the max priority queue.
module mpq_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mpq_pkg::t_cmd i_cmd,
    input  logic [1:0]    i_mode,
    input  logic [31:0]   i_pri,
    input  logic [31:0]   i_val,
    input  logic [31:0]   i_key,
    input  logic          i_out_ready,
    output mpq_pkg::t_stat o_stat,
    output logic          o_out_valid,
    output logic [31:0]   o_pri,
    output logic [31:0]   o_val,
    output logic [1:0]    o_status,
    output logic [4:0]    o_occ
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(DEPTH + 1);

    logic signed [DATA_WIDTH-1:0] r_pri [DEPTH];
    logic signed [DATA_WIDTH-1:0] r_val [DEPTH];
    logic signed [DATA_WIDTH-1:0] n_pri [DEPTH];
    logic signed [DATA_WIDTH-1:0] n_val [DEPTH];
    logic [CW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_pass;
    logic [1:0]    r_mode;
    logic signed [DATA_WIDTH-1:0] r_ipri, r_ival, r_ikey;
    logic [31:0]   r_rpri, r_rval;
    logic [1:0]    r_rst;
    logic [31:0]   r_opri, r_oval;
    logic [1:0]    r_ost;
    logic [4:0]    r_oocc;
    logic          r_ovld;

    logic [DEPTH-1:0] lt, hit, live;
    logic [31:0] f_pri, f_val;
    logic        f_any;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            live[i] = CW'(i) < r_cnt;
            lt[i]   = live[i] && (r_pri[i] < r_ipri);
            hit[i]  = live[i] && (r_val[i] == r_ikey);
        end
    end

    // lowest matching cell
    always_comb begin
        f_any = 1'b0;
        f_pri = '0;
        f_val = '1;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (hit[i]) begin
                f_any = 1'b1;
                f_pri = 32'(r_pri[i]);
                f_val = 32'(r_val[i]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_pri[i] = r_pri[i];
            n_val[i] = r_val[i];
        end
        n_cnt = r_cnt;
        if (i_cmd.exec && r_mode == mpq_pkg::MODE_ENQ && r_cnt != CW'(DEPTH)) begin
            n_cnt = r_cnt + 1'b1;
            for (int i = 0; i < DEPTH; i++) begin
                if (lt[i]) begin
                    if (i > 0 && lt[i-1]) begin
                        n_pri[i] = r_pri[i-1];
                        n_val[i] = r_val[i-1];
                    end else begin
                        n_pri[i] = r_ipri;
                        n_val[i] = r_ival;
                    end
                end else if (CW'(i) == r_cnt && (i == 0 || !lt[i-1])) begin
                    n_pri[i] = r_ipri;
                    n_val[i] = r_ival;
                end else if (CW'(i) == r_cnt) begin
                    n_pri[i] = r_pri[i-1];
                    n_val[i] = r_val[i-1];
                end
            end
        end else if (i_cmd.exec && r_mode == mpq_pkg::MODE_DEQ && r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_pri[i] = r_pri[i+1];
                n_val[i] = r_val[i+1];
            end
        end else if (i_cmd.swap) begin
            for (int i = 0; i < DEPTH; i++) begin
                n_pri[i] = r_val[i];
                n_val[i] = r_pri[i];
            end
        end else if (i_cmd.sort) begin
            // odd-even transposition, stable: swap only on strict less
            for (int i = 0; i < DEPTH - 1; i++) begin
                if ((i % 2) == int'(r_pass[0]) && live[i+1] && r_pri[i] < r_pri[i+1]) begin
                    n_pri[i]   = r_pri[i+1];
                    n_val[i]   = r_val[i+1];
                    n_pri[i+1] = r_pri[i];
                    n_val[i+1] = r_val[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_pri[i] <= n_pri[i];
            r_val[i] <= n_val[i];
        end
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_ipri <= i_pri[DATA_WIDTH-1:0];
            r_ival <= i_val[DATA_WIDTH-1:0];
            r_ikey <= i_key[DATA_WIDTH-1:0];
        end
        if (i_cmd.exec || i_cmd.swap) begin
            r_rpri <= '0;
            r_rval <= '0;
            r_rst  <= mpq_pkg::ST_OK;
            if (i_cmd.exec) begin
                unique case (r_mode)
                    mpq_pkg::MODE_ENQ: begin
                        if (r_cnt == CW'(DEPTH)) r_rst <= mpq_pkg::ST_FULL;
                    end
                    mpq_pkg::MODE_DEQ: begin
                        if (r_cnt == '0) begin
                            r_rst  <= mpq_pkg::ST_EMPTY;
                            r_rval <= '1;
                        end else begin
                            r_rpri <= 32'(r_pri[0]);
                            r_rval <= 32'(r_val[0]);
                        end
                    end
                    default: begin
                        r_rpri <= f_pri;
                        r_rval <= f_val;
                        if (!f_any) r_rst <= mpq_pkg::ST_NOTFOUND;
                    end
                endcase
            end
        end
        if (i_cmd.emit) begin
            r_opri <= r_rpri;
            r_oval <= r_rval;
            r_ost  <= r_rst;
            r_oocc <= 5'(r_cnt);
        end
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pass <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_pass <= i_cmd.sort ? r_pass + 1'b1 : '0;
            if (i_cmd.emit)       r_ovld <= 1'b1;
            else if (i_out_ready) r_ovld <= 1'b0;
        end
    end

    assign o_stat.sort_done = i_cmd.sort && (r_pass == SW'(DEPTH - 1));
    assign o_out_valid = r_ovld;
    assign o_pri       = r_opri;
    assign o_val       = r_oval;
    assign o_status    = r_ost;
    assign o_occ       = r_oocc;
endmodule

/* rtl/max_priority_queue.sv */
// Top level of the max priority queue: controller plus sorted cell chain.
// Enqueue, dequeue and lookup: the word is captured, executed in EXEC, then emitted in OUT.
// Swap: fields are exchanged, then the odd-even transposition sort runs DEPTH passes.
// The single-entry output register sets the rate: the next word is accepted
// once the previous result has moved into it.
// Synchronous active-low reset empties the store and drops any pending result.
module max_priority_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] mode, [33:2] priority_req, [65:34] item_value, [97:66] search_value
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] out_priority, [63:32] out_value, [65:64] status, [70:66] occupancy
    output logic [71:0]  m_axis_tdata
);
    mpq_pkg::t_cmd  cmd;
    mpq_pkg::t_stat stat;
    logic [31:0] out_pri, out_val;
    logic [1:0]  out_st;
    logic [4:0]  out_occ;

    // output register busy: a result still waits and is not taken now
    mpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_mode     (mpq_pkg::t_mode'(s_axis_tdata[1:0])),
        .i_out_busy (m_axis_tvalid && !m_axis_tready),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    mpq_datapath #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_mode      (s_axis_tdata[1:0]),
        .i_pri       (s_axis_tdata[33:2]),
        .i_val       (s_axis_tdata[65:34]),
        .i_key       (s_axis_tdata[97:66]),
        .i_out_ready (m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .o_pri       (out_pri),
        .o_val       (out_val),
        .o_status    (out_st),
        .o_occ       (out_occ)
    );

    assign m_axis_tdata = {1'b0, out_occ, out_st, out_val, out_pri};

`ifndef NO_ASSERTIONS
    // a stalled result word holds until it is taken
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word changed while stalled");
    // every accepted word is followed by work, not by another accept
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("back to back accept");
    // occupancy never exceeds depth on a result
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[70:66]) <= 32'(DEPTH)))
        else $error("occupancy beyond depth");
`endif
endmodule
